[hw/rtl/mbe_pkg.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared types and constants for the escape-time iteration block.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int unsigned IN_FRAC     = 28;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COUNT_OUT_W = 16;
  localparam int unsigned GREEN_W     = 8;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [COUNT_OUT_W-1:0] MAX_ITER_RESET = 16'd100;
  localparam logic                   REG_IDX_MAX    = 1'b0;

  localparam logic [GREEN_W-1:0] GREEN_INIT = 8'd2;
  localparam logic [GREEN_W-1:0] GREEN_STEP = 8'd2;
  localparam logic [GREEN_W-1:0] GREEN_MOD  = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_SQY,
    ST_CROSS,
    ST_UPDATE,
    ST_DONE
  } st_e;

  typedef enum logic [1:0] {
    MUL_XX,
    MUL_YY,
    MUL_XY
  } mul_op_e;

  typedef struct packed {
    logic [GREEN_W-1:0]     green;
    logic [COUNT_OUT_W-1:0] count;
  } res_t;

endpackage

[hw/rtl/mbe_regs.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape-time configuration registers
// APB-style register port holding the iteration limit.
// ----------------------------------------------------------------------------
module mbe_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbe_pkg::PADDR_W-1:0] paddr,
  input  logic [mbe_pkg::PDATA_W-1:0] pwdata,
  output logic [mbe_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [mbe_pkg::COUNT_OUT_W-1:0] max_iter_o
);
  import mbe_pkg::*;

  logic [COUNT_OUT_W-1:0] max_iter_q;
  logic                   wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RESET;
    end else if (wr_en) begin
      max_iter_q <= pwdata[COUNT_OUT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_IDX_MAX) begin
      prdata = PDATA_W'(max_iter_q);
    end
  end

  assign max_iter_o = max_iter_q;

endmodule

[hw/rtl/mbe_mul.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape-time shared multiplier
// Signed fixed-point product, optionally doubled, with floor truncation and a registered result.
// ----------------------------------------------------------------------------
module mbe_mul #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        dbl_i,
  input  logic signed [FRAC_BITS+1:0] a_i,
  input  logic signed [FRAC_BITS+1:0] b_i,
  output logic signed [FRAC_BITS+3:0] p_o
);
  import mbe_pkg::*;

  localparam int unsigned MW = FRAC_BITS + 2;
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned RW = FRAC_BITS + 4;

  logic signed [PW-1:0] full;
  logic signed [PW-1:0] shifted;
  logic signed [RW-1:0] p_q;

  assign full    = a_i * b_i;
  assign shifted = dbl_i ? (full >>> (FRAC_BITS - 1)) : (full >>> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= shifted[RW-1:0];
    end
  end

  assign p_o = p_q;

endmodule

[hw/rtl/mbe_core.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape-time core
// Sequencer and datapath that iterate z = z*z + c on one shared multiplier.
// ----------------------------------------------------------------------------
module mbe_core #(
  parameter int unsigned FRAC_BITS   = 28,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mbe_pkg::DATA_W-1:0]      point_real_i,
  input  logic [mbe_pkg::DATA_W-1:0]      point_imag_i,
  input  logic [mbe_pkg::COUNT_OUT_W-1:0] max_iter_i,
  output logic                            in_ready_o,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output mbe_pkg::res_t                   res_o
);
  import mbe_pkg::*;

  localparam int unsigned CW  = FRAC_BITS + 4;
  localparam int unsigned ZW  = FRAC_BITS + 5;
  localparam int unsigned MW  = FRAC_BITS + 2;
  localparam int unsigned RW  = FRAC_BITS + 4;
  localparam int unsigned LW  = (COUNT_WIDTH > COUNT_OUT_W) ? COUNT_WIDTH : COUNT_OUT_W;
  localparam int unsigned LSH = (FRAC_BITS >= IN_FRAC) ? (FRAC_BITS - IN_FRAC) : 0;
  localparam int unsigned RSH = (FRAC_BITS < IN_FRAC) ? (IN_FRAC - FRAC_BITS) : 0;

  localparam logic signed [ZW-1:0] TWO_Z   = ZW'(2) <<< FRAC_BITS;
  localparam logic        [RW:0]   FOUR_SQ = (RW + 1)'(4) << FRAC_BITS;

  st_e state_q, state_d;

  logic signed [CW-1:0]   cx_q, cy_q;
  logic signed [ZW-1:0]   zx_q, zy_q;
  logic signed [RW-1:0]   sx_q, sy_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic [GREEN_W-1:0]     green_q;

  logic signed [DATA_W-1:0] pr_sh, pi_sh;
  logic signed [CW-1:0]     cx_in, cy_in;
  logic signed [ZW-1:0]     zx_d, zy_d;
  logic signed [MW-1:0]     zx_m, zy_m;
  logic signed [MW-1:0]     mul_a, mul_b;
  logic signed [RW-1:0]     prod;
  logic                     mul_en, mul_dbl;
  mul_op_e                  mul_op;
  logic                     at_limit, z_in_range, stop_test, escape;
  logic [RW:0]              sq_sum;
  logic [GREEN_W:0]         green_sum;
  logic [GREEN_W-1:0]       green_d;

  assign pr_sh = $signed(point_real_i) >>> RSH;
  assign pi_sh = $signed(point_imag_i) >>> RSH;
  assign cx_in = CW'(pr_sh) <<< LSH;
  assign cy_in = CW'(pi_sh) <<< LSH;

  assign at_limit   = (LW'(count_q) >= LW'(max_iter_i)) || (&count_q);
  assign z_in_range = (zx_q < TWO_Z) && (zx_q > -TWO_Z) && (zy_q < TWO_Z) && (zy_q > -TWO_Z);
  assign stop_test  = at_limit || !z_in_range;

  assign sq_sum = {1'b0, sx_q} + {1'b0, sy_q};
  assign escape = (sq_sum >= FOUR_SQ);

  assign zx_d = ZW'(sx_q) - ZW'(sy_q) + ZW'(cx_q);
  assign zy_d = ZW'(prod) + ZW'(cy_q);

  assign green_sum = {1'b0, green_q} + (GREEN_W + 1)'(GREEN_STEP);
  assign green_d   = (green_sum >= (GREEN_W + 1)'(GREEN_MOD)) ?
                     GREEN_W'(green_sum - (GREEN_W + 1)'(GREEN_MOD)) : green_sum[GREEN_W-1:0];

  assign zx_m = zx_q[MW-1:0];
  assign zy_m = zy_q[MW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        state_d = stop_test ? ST_DONE : ST_SQY;
      end
      ST_SQY: begin
        state_d = ST_CROSS;
      end
      ST_CROSS: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = escape ? ST_DONE : ST_TEST;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mul_en      = 1'b0;
    mul_op      = MUL_XX;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_TEST: begin
        mul_en = 1'b1;
        mul_op = MUL_XX;
      end
      ST_SQY: begin
        mul_en = 1'b1;
        mul_op = MUL_YY;
      end
      ST_CROSS: begin
        mul_en = 1'b1;
        mul_op = MUL_XY;
      end
      ST_UPDATE: begin
        mul_en = 1'b0;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    mul_a   = zx_m;
    mul_b   = zx_m;
    mul_dbl = 1'b0;
    unique case (mul_op)
      MUL_XX: begin
        mul_a = zx_m;
        mul_b = zx_m;
      end
      MUL_YY: begin
        mul_a = zy_m;
        mul_b = zy_m;
      end
      MUL_XY: begin
        mul_a   = zx_m;
        mul_b   = zy_m;
        mul_dbl = 1'b1;
      end
      default: begin
        mul_dbl = 1'b0;
      end
    endcase
  end

  mbe_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .dbl_i (mul_dbl),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && start_i) begin
      cx_q    <= cx_in;
      cy_q    <= cy_in;
      zx_q    <= '0;
      zy_q    <= '0;
      count_q <= '0;
      green_q <= GREEN_INIT;
    end
    if (state_q == ST_SQY) begin
      sx_q <= prod;
    end
    if (state_q == ST_CROSS) begin
      sy_q <= prod;
    end
    if ((state_q == ST_UPDATE) && !escape) begin
      zx_q    <= zx_d;
      zy_q    <= zy_d;
      count_q <= count_q + COUNT_WIDTH'(1);
      green_q <= green_d;
    end
  end

  assign res_o.count = COUNT_OUT_W'(count_q);
  assign res_o.green = green_q;

endmodule

[hw/rtl/mandelbrot_escape_time_top.sv]
// The block works on one point at a time; each iteration of z = z*z + c runs three products on
// the shared multiplier (x*x, y*y, 2*x*y) and then an update, so no new point is taken until
// the result of the last one has left the core.
// A finished result waits in the output register while the next point is taken.
// Reset is asynchronous and active low; it clears the control state and sets the
// iteration limit to 100.
// ----------------------------------------------------------------------------
// Mandelbrot escape-time top level
// Stream ports, configuration port, iteration core and output register.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top #(
  parameter int unsigned FRAC_BITS   = 28,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,  // point_real, point_imag
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,  // iteration_count, green_level
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbe_pkg::PADDR_W-1:0] paddr,
  input  logic [mbe_pkg::PDATA_W-1:0] pwdata,
  output logic [mbe_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import mbe_pkg::*;

  logic [COUNT_OUT_W-1:0] max_iter;
  logic                   core_res_valid, core_res_ready;
  res_t                   core_res;
  res_t                   out_q;
  logic                   out_valid_q;

  mbe_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_iter_o (max_iter)
  );

  mbe_core #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (s_axis_tvalid),
    .point_real_i (s_axis_tdata[31:0]),
    .point_imag_i (s_axis_tdata[63:32]),
    .max_iter_i   (max_iter),
    .in_ready_o   (s_axis_tready),
    .res_valid_o  (core_res_valid),
    .res_ready_i  (core_res_ready),
    .res_o        (core_res)
  );

  assign core_res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_res_valid && core_res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_res_valid && core_res_ready) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.green, out_q.count};

`ifndef SYNTHESIS
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("block still ready after taking a point");

  a_count_within_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (core_res_valid && core_res_ready) |-> (core_res.count <= max_iter))
    else $error("iteration count beyond the configured limit");

  a_green_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.green != 8'hFF))
    else $error("green level out of range");
`endif

endmodule
